// ===== hdl/cbfm_pkg.sv =====
// shared types, codes and controller interface of the clock buffer frame manager
package cbfm_pkg;

  localparam int NUM_FRAMES_DEF = 16;
  localparam int FRAME_W        = 6;
  localparam int TAG_W          = 40;

  localparam logic [2:0] FN_READ    = 3'd0;
  localparam logic [2:0] FN_UNPIN   = 3'd1;
  localparam logic [2:0] FN_ALLOC   = 3'd2;
  localparam logic [2:0] FN_DISPOSE = 3'd3;
  localparam logic [2:0] FN_FLUSH   = 3'd4;

  localparam logic [2:0] ST_HIT        = 3'd0;
  localparam logic [2:0] ST_ALLOCATED  = 3'd1;
  localparam logic [2:0] ST_EXCEEDED   = 3'd2;
  localparam logic [2:0] ST_NOT_PINNED = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
  localparam logic [2:0] ST_PINNED     = 3'd5;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  file_id;
    logic [31:0] page_no;
    logic        set_dirty;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [FRAME_W-1:0] frame;
    logic               disk_read;
    logic               writeback;
    logic [7:0]         wb_file;
    logic [31:0]        wb_page;
    logic               last;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic find;
    logic dispatch;
    logic sweep;
    logic swrd;
    logic flrd;
    logic flchk;
    logic flend;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic find_done;
    logic found;
    logic is_rdal;
    logic is_flush;
    logic out_busy;
    logic sw_take;
    logic sw_exh;
    logic fl_stop;
    logic fl_end;
  } sts_t;

endpackage

// ===== hdl/cbfm_ctrl.sv =====
// sequencing state machine of the frame manager
module cbfm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  cbfm_pkg::sts_t sts,
  output cbfm_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FIND  = 7'b0000010,
    S_SWEEP = 7'b0000100,
    S_SWRD  = 7'b0001000,
    S_FLRD  = 7'b0010000,
    S_FLCHK = 7'b0100000,
    S_FLEND = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        cmd.find = 1'b1;
        if (sts.find_done && !sts.out_busy) begin
          cmd.dispatch = 1'b1;
          if (sts.is_rdal && !sts.found) begin
            state_next = S_SWEEP;
          end else if (sts.is_flush) begin
            state_next = S_FLRD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_SWEEP: begin
        if (!sts.out_busy) begin
          cmd.sweep = 1'b1;
          if (sts.sw_take) begin
            state_next = S_SWRD;
          end else if (sts.sw_exh) begin
            state_next = S_IDLE;
          end
        end
      end
      S_SWRD: begin
        if (!sts.out_busy) begin
          cmd.swrd   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FLRD: begin
        if (!sts.out_busy) begin
          cmd.flrd   = 1'b1;
          state_next = S_FLCHK;
        end
      end
      S_FLCHK: begin
        cmd.flchk = 1'b1;
        if (sts.fl_stop) begin
          state_next = S_IDLE;
        end else if (sts.fl_end) begin
          state_next = S_FLEND;
        end else begin
          state_next = S_FLRD;
        end
      end
      S_FLEND: begin
        if (!sts.out_busy) begin
          cmd.flend  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/cbfm_dp.sv =====
// frame table, tag memory, clock hand and result register
module cbfm_dp #(
  parameter int NUM_FRAMES = cbfm_pkg::NUM_FRAMES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  cbfm_pkg::req_t req,
  input  cbfm_pkg::cmd_t cmd,
  output cbfm_pkg::sts_t sts,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output cbfm_pkg::rsp_t rsp
);

  localparam int IW = $clog2(NUM_FRAMES);
  localparam int CW = IW + 2;
  localparam logic [CW-1:0] N_C    = CW'(NUM_FRAMES);
  localparam logic [CW-1:0] SW_MAX = CW'(2 * NUM_FRAMES - 1);
  localparam logic [CW-1:0] FL_MAX = CW'(NUM_FRAMES - 1);
  localparam logic [IW-1:0] H_MAX  = IW'(NUM_FRAMES - 1);

  // tag memory, contents undefined until a frame is taken
  logic [cbfm_pkg::TAG_W-1:0] tag_mem [NUM_FRAMES];
  logic [cbfm_pkg::TAG_W-1:0] rd_data;
  logic [IW-1:0]              rd_addr, addr_q;

  logic [NUM_FRAMES-1:0] fvalid, fref, fdirty;
  logic [7:0]            pins [NUM_FRAMES];
  logic [IW-1:0]         hand;

  cbfm_pkg::req_t r;
  logic [CW-1:0]  cnt;
  logic           pv, found, wbf;
  logic [IW-1:0]  pidx, fidx, victim;
  cbfm_pkg::rsp_t pend;
  logic           pend_v;

  logic [IW-1:0]  h, ci;
  logic           take, fl_match, fl_pinned, tag_hit;
  cbfm_pkg::rsp_t item;

  // single final result with status and frame only
  function automatic cbfm_pkg::rsp_t short_rsp(logic [2:0] st, logic [IW-1:0] fr);
    cbfm_pkg::rsp_t x;
    x        = '0;
    x.status = st;
    x.frame  = cbfm_pkg::FRAME_W'(fr);
    x.last   = 1'b1;
    return x;
  endfunction

  // same result flagged as the final one
  function automatic cbfm_pkg::rsp_t mark_last(cbfm_pkg::rsp_t x);
    cbfm_pkg::rsp_t y;
    y      = x;
    y.last = 1'b1;
    return y;
  endfunction

  // allocation result, old tag only when a writeback is due
  function automatic cbfm_pkg::rsp_t alloc_rsp(logic [IW-1:0] fr, logic dr, logic wb,
                                               logic [cbfm_pkg::TAG_W-1:0] old_tag);
    cbfm_pkg::rsp_t x;
    x           = '0;
    x.status    = cbfm_pkg::ST_ALLOCATED;
    x.frame     = cbfm_pkg::FRAME_W'(fr);
    x.disk_read = dr;
    x.writeback = wb;
    x.wb_file   = wb ? old_tag[39:32] : 8'd0;
    x.wb_page   = wb ? old_tag[31:0] : 32'd0;
    x.last      = 1'b1;
    return x;
  endfunction

  assign h   = (hand == H_MAX) ? '0 : hand + 1'b1;
  assign ci  = cnt[IW-1:0];
  assign take = !fvalid[h] || (!fref[h] && (pins[h] == 8'd0));
  assign fl_match  = fvalid[ci] && (rd_data[39:32] == r.file_id);
  assign fl_pinned = (pins[ci] != 8'd0);
  assign tag_hit   = fvalid[pidx] && (rd_data == {r.file_id, r.page_no});

  always_comb begin
    rd_addr = addr_q;
    if (cmd.find && (cnt < N_C)) begin
      rd_addr = ci;
    end else if (cmd.sweep) begin
      rd_addr = h;
    end else if (cmd.flrd) begin
      rd_addr = ci;
    end
  end

  always_ff @(posedge clk) begin
    addr_q  <= rd_addr;
    rd_data <= tag_mem[rd_addr];
    if (cmd.swrd) begin
      tag_mem[victim] <= {r.file_id, r.page_no};
    end
  end

  assign sts.find_done = (cnt == N_C) && !pv;
  assign sts.found     = found;
  assign sts.is_rdal   = (r.func == cbfm_pkg::FN_READ) || (r.func == cbfm_pkg::FN_ALLOC);
  assign sts.is_flush  = (r.func == cbfm_pkg::FN_FLUSH);
  assign sts.out_busy  = rsp_valid;
  assign sts.sw_take   = take;
  assign sts.sw_exh    = !take && (cnt == SW_MAX);
  assign sts.fl_stop   = fl_match && fl_pinned && !pend_v;
  assign sts.fl_end    = (fl_match && fl_pinned && pend_v) ||
                         (!(fl_match && fl_pinned) && (cnt == FL_MAX));

  always_comb begin
    item = '0;
    item.frame = cbfm_pkg::FRAME_W'(ci);
    if (fl_pinned) begin
      item.status = cbfm_pkg::ST_PINNED;
    end else begin
      item.status    = cbfm_pkg::ST_HIT;
      item.writeback = 1'b1;
      item.wb_file   = rd_data[39:32];
      item.wb_page   = rd_data[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid    <= '0;
      fref      <= '0;
      fdirty    <= '0;
      hand      <= H_MAX;
      rsp_valid <= 1'b0;
      pend_v    <= 1'b0;
      pv        <= 1'b0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        pins[i] <= 8'd0;
      end
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cmd.load) begin
        r      <= req;
        cnt    <= '0;
        pv     <= 1'b0;
        found  <= 1'b0;
        pend_v <= 1'b0;
      end
      if (cmd.find) begin
        if (cnt < N_C) begin
          pv   <= 1'b1;
          pidx <= ci;
          cnt  <= cnt + 1'b1;
        end else begin
          pv <= 1'b0;
        end
        if (pv && tag_hit && !found) begin
          found <= 1'b1;
          fidx  <= pidx;
        end
      end
      if (cmd.dispatch) begin
        cnt <= '0;
        if (sts.is_rdal) begin
          if (found) begin
            fref[fidx] <= 1'b1;
            if (pins[fidx] != 8'hff) begin
              pins[fidx] <= pins[fidx] + 8'd1;
            end
            rsp       <= short_rsp(cbfm_pkg::ST_HIT, fidx);
            rsp_valid <= 1'b1;
          end
        end else if (r.func == cbfm_pkg::FN_UNPIN) begin
          rsp_valid <= 1'b1;
          if (!found) begin
            rsp <= short_rsp(cbfm_pkg::ST_NOT_FOUND, '0);
          end else if (pins[fidx] == 8'd0) begin
            rsp <= short_rsp(cbfm_pkg::ST_NOT_PINNED, fidx);
          end else begin
            pins[fidx] <= pins[fidx] - 8'd1;
            if (r.set_dirty) begin
              fdirty[fidx] <= 1'b1;
            end
            rsp <= short_rsp(cbfm_pkg::ST_HIT, fidx);
          end
        end else if (r.func == cbfm_pkg::FN_DISPOSE) begin
          rsp_valid <= 1'b1;
          if (!found) begin
            rsp <= short_rsp(cbfm_pkg::ST_NOT_FOUND, '0);
          end else begin
            fvalid[fidx] <= 1'b0;
            fref[fidx]   <= 1'b0;
            fdirty[fidx] <= 1'b0;
            pins[fidx]   <= 8'd0;
            rsp          <= short_rsp(cbfm_pkg::ST_HIT, fidx);
          end
        end else if (!sts.is_flush) begin
          rsp_valid <= 1'b1;
          rsp       <= short_rsp(cbfm_pkg::ST_NOT_FOUND, '0);
        end
      end
      if (cmd.sweep) begin
        hand <= h;
        cnt  <= cnt + 1'b1;
        if (take) begin
          victim    <= h;
          wbf       <= fvalid[h] && fdirty[h];
          fvalid[h] <= 1'b1;
          fref[h]   <= 1'b1;
          fdirty[h] <= 1'b0;
          pins[h]   <= 8'd1;
        end else begin
          fref[h] <= 1'b0;
          if (cnt == SW_MAX) begin
            rsp       <= short_rsp(cbfm_pkg::ST_EXCEEDED, '0);
            rsp_valid <= 1'b1;
          end
        end
      end
      if (cmd.swrd) begin
        rsp       <= alloc_rsp(victim, (r.func == cbfm_pkg::FN_READ), wbf, rd_data);
        rsp_valid <= 1'b1;
      end
      if (cmd.flchk) begin
        if (fl_match && fl_pinned) begin
          if (pend_v) begin
            rsp       <= pend;
            rsp_valid <= 1'b1;
            pend      <= item;
          end else begin
            rsp       <= mark_last(item);
            rsp_valid <= 1'b1;
          end
        end else begin
          cnt <= cnt + 1'b1;
          if (fl_match) begin
            fvalid[ci] <= 1'b0;
            fref[ci]   <= 1'b0;
            fdirty[ci] <= 1'b0;
            pins[ci]   <= 8'd0;
            if (fdirty[ci]) begin
              if (pend_v) begin
                rsp       <= pend;
                rsp_valid <= 1'b1;
              end
              pend   <= item;
              pend_v <= 1'b1;
            end
          end
        end
      end
      if (cmd.flend) begin
        if (pend_v) begin
          rsp <= mark_last(pend);
        end else begin
          rsp <= short_rsp(cbfm_pkg::ST_HIT, '0);
        end
        rsp_valid <= 1'b1;
        pend_v    <= 1'b0;
      end
    end
  end

  a_hand_range: assert property (@(posedge clk) disable iff (rst)
    hand <= H_MAX)
    else $error("clock hand out of range");

  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.sweep && take) |=> fvalid[victim] && (pins[victim] == 8'd1))
    else $error("taken frame not marked resident and pinned");

  a_dispatch_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.dispatch || cmd.swrd || cmd.flend) |-> !rsp_valid)
    else $error("result register loaded while occupied");

  a_pend_flush: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> (r.func == cbfm_pkg::FN_FLUSH))
    else $error("pending flush result outside flush");

endmodule

// ===== hdl/clock_buffer_frame_manager.sv =====
// top level of the clock replacement buffer frame manager
// Each request transaction is looked up by scanning the tag memory one frame per
// cycle. A read or allocate miss then runs the clock sweep at one frame per cycle,
// up to 2*NUM_FRAMES steps, and then reads the victim's old tag for a writeback.
// A flush walks the frames, each with a tag memory read and then a check, and may
// issue several result transactions, the last one flagged. The lookup scan over
// the single tag memory read port sets the floor of the time per request. One
// request is in work at a time; a new request is taken as soon as the previous
// one has queued its final result, even while that result still waits to be
// taken. No clearing pass after reset: frame marks sit in flip-flops that reset
// clears.
module clock_buffer_frame_manager #(
  parameter int NUM_FRAMES = cbfm_pkg::NUM_FRAMES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  // request channel
  input  logic           req_valid,
  output logic           req_stall,
  input  cbfm_pkg::req_t req,
  // result channel
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output cbfm_pkg::rsp_t rsp
);

  cbfm_pkg::cmd_t cmd;
  cbfm_pkg::sts_t sts;

  // controller: lookup, sweep and flush sequencing
  cbfm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: frame marks, tags, hand and result register
  cbfm_dp #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== tb/tb_clock_buffer_frame_manager.sv =====
// testbench of the clock buffer frame manager: random and directed requests checked by a predictor
`timescale 1ns / 1ps

module tb_clock_buffer_frame_manager;

  localparam int NF = cbfm_pkg::NUM_FRAMES_DEF;
  localparam int LIMIT_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  cbfm_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  cbfm_pkg::rsp_t rsp;

  clock_buffer_frame_manager #(.NUM_FRAMES(NF)) i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #2 clk = ~clk;

  // predictor copy of the frame table
  logic        pool_valid [NF];
  logic [7:0]  pool_pins  [NF];
  logic        pool_ref   [NF];
  logic        pool_dirty [NF];
  logic [7:0]  pool_file  [NF];
  logic [31:0] pool_page  [NF];
  int          clock_hand;

  cbfm_pkg::req_t pending_reqs[$];
  cbfm_pkg::rsp_t expected_rsps[$];
  int   errors = 0;
  int   cycles = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  // a few files and pages so that hits, pins and flushes recur
  logic [7:0]  file_pool [4] = '{8'h00, 8'hff, 8'h5a, 8'h81};

  function automatic cbfm_pkg::rsp_t mk_rsp(logic [2:0] st, int fr, logic dr, logic wb,
                                            logic [7:0] wf, logic [31:0] wp, logic lst);
    cbfm_pkg::rsp_t r;
    r.status = st; r.frame = fr[cbfm_pkg::FRAME_W-1:0]; r.disk_read = dr; r.writeback = wb;
    r.wb_file = wf; r.wb_page = wp; r.last = lst;
    return r;
  endfunction

  function automatic int lookup_frame(logic [7:0] f, logic [31:0] p);
    for (int i = 0; i < NF; i++)
      if (pool_valid[i] && pool_file[i] == f && pool_page[i] == p) return i;
    return -1;
  endfunction

  function automatic void drop_frame(int i);
    pool_valid[i] = 0; pool_pins[i] = 0; pool_ref[i] = 0; pool_dirty[i] = 0;
  endfunction

  // clock sweep, bounded at two passes over the table
  function automatic int clock_victim();
    for (int i = 0; i < 2 * NF; i++) begin
      clock_hand = (clock_hand + 1) % NF;
      if (!pool_valid[clock_hand]) return clock_hand;
      if (pool_ref[clock_hand]) begin
        pool_ref[clock_hand] = 0;
        continue;
      end
      if (pool_pins[clock_hand] == 0) return clock_hand;
    end
    return -1;
  endfunction

  task automatic predict_request(cbfm_pkg::req_t r);
    int fr;
    int n;
    cbfm_pkg::rsp_t x;
    fr = lookup_frame(r.file_id, r.page_no);
    n = 0;
    case (r.func)
      cbfm_pkg::FN_READ, cbfm_pkg::FN_ALLOC: begin
        if (fr >= 0) begin
          pool_ref[fr] = 1;
          if (pool_pins[fr] != 8'hff) pool_pins[fr]++;
          expected_rsps.push_back(mk_rsp(cbfm_pkg::ST_HIT, fr, 0, 0, 0, 0, 1));
        end else begin
          fr = clock_victim();
          if (fr < 0)
            expected_rsps.push_back(mk_rsp(cbfm_pkg::ST_EXCEEDED, 0, 0, 0, 0, 0, 1));
          else begin
            if (pool_valid[fr] && pool_dirty[fr])
              x = mk_rsp(cbfm_pkg::ST_ALLOCATED, fr, 0, 1, pool_file[fr], pool_page[fr], 1);
            else x = mk_rsp(cbfm_pkg::ST_ALLOCATED, fr, 0, 0, 0, 0, 1);
            x.disk_read = (r.func == cbfm_pkg::FN_READ);
            pool_file[fr] = r.file_id; pool_page[fr] = r.page_no;
            pool_valid[fr] = 1; pool_pins[fr] = 1; pool_ref[fr] = 1; pool_dirty[fr] = 0;
            expected_rsps.push_back(x);
          end
        end
      end
      cbfm_pkg::FN_UNPIN: begin
        if (fr < 0)
          expected_rsps.push_back(mk_rsp(cbfm_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 0, 1));
        else if (pool_pins[fr] == 0)
          expected_rsps.push_back(mk_rsp(cbfm_pkg::ST_NOT_PINNED, fr, 0, 0, 0, 0, 1));
        else begin
          pool_pins[fr]--;
          if (r.set_dirty) pool_dirty[fr] = 1;
          expected_rsps.push_back(mk_rsp(cbfm_pkg::ST_HIT, fr, 0, 0, 0, 0, 1));
        end
      end
      cbfm_pkg::FN_DISPOSE: begin
        if (fr < 0)
          expected_rsps.push_back(mk_rsp(cbfm_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 0, 1));
        else begin
          drop_frame(fr);
          expected_rsps.push_back(mk_rsp(cbfm_pkg::ST_HIT, fr, 0, 0, 0, 0, 1));
        end
      end
      cbfm_pkg::FN_FLUSH: begin
        for (int i = 0; i < NF; i++) begin
          if (!pool_valid[i] || pool_file[i] != r.file_id) continue;
          if (pool_pins[i] != 0) begin
            expected_rsps.push_back(mk_rsp(cbfm_pkg::ST_PINNED, i, 0, 0, 0, 0, 0));
            n++;
            break;
          end
          if (pool_dirty[i]) begin
            expected_rsps.push_back(mk_rsp(cbfm_pkg::ST_HIT, i, 0, 1, pool_file[i],
                                           pool_page[i], 0));
            n++;
          end
          drop_frame(i);
        end
        // final result of the flush carries the last flag
        if (n == 0) expected_rsps.push_back(mk_rsp(cbfm_pkg::ST_HIT, 0, 0, 0, 0, 0, 1));
        else expected_rsps[expected_rsps.size() - 1].last = 1'b1;
      end
      default: expected_rsps.push_back(mk_rsp(cbfm_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 0, 1));
    endcase
  endtask

  function automatic cbfm_pkg::req_t mk_req(logic [2:0] fn, logic [7:0] f, logic [31:0] p,
                                            logic sd);
    cbfm_pkg::req_t r;
    r.func = fn; r.file_id = f; r.page_no = p; r.set_dirty = sd;
    return r;
  endfunction

  // random request, mostly reusing a small set of tags so that the table fills up
  function automatic cbfm_pkg::req_t rand_req();
    logic [2:0]  fn;
    logic [7:0]  f;
    logic [31:0] p;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) fn = cbfm_pkg::FN_READ;
    else if (sel < 65) fn = cbfm_pkg::FN_UNPIN;
    else if (sel < 77) fn = cbfm_pkg::FN_ALLOC;
    else if (sel < 87) fn = cbfm_pkg::FN_DISPOSE;
    else if (sel < 95) fn = cbfm_pkg::FN_FLUSH;
    else fn = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 9) == 0) begin
      f = 8'($urandom);
      p = $urandom;
    end else begin
      f = file_pool[$urandom_range(0, 3)];
      p = ($urandom_range(0, 1) == 1) ? 32'($urandom_range(0, 11))
                                       : 32'hffff_fff0 + 32'($urandom_range(0, 15));
    end
    return mk_req(fn, f, p, 1'($urandom));
  endfunction

  // driver: offers the next pending transaction, holds it while stalled
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (!req_valid || !req_stall) begin
        if (req_valid) predict_request(req);
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // monitor: every result transaction against the oldest expectation
  always @(posedge clk) begin
    cbfm_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, rsp);
        errors <= errors + 1;
      end else begin
        want = expected_rsps.pop_front();
        if (want !== rsp) begin
          $display("%0t: result mismatch, expected %p, actual %p", $time, want, rsp);
          errors <= errors + 1;
        end
      end
    end
  end

  // timeout guard
  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_clock_buffer_frame_manager: errors");
      $finish;
    end
  end

  task automatic drain_phase();
    while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int nrand;
    for (int i = 0; i < NF; i++) begin
      drop_frame(i);
      pool_file[i] = 0; pool_page[i] = 0;
    end
    clock_hand = NF - 1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty-table misses, unused codes, field extremes
    pending_reqs.push_back(mk_req(cbfm_pkg::FN_UNPIN, 8'h00, 32'h0, 1'b0));
    pending_reqs.push_back(mk_req(cbfm_pkg::FN_DISPOSE, 8'hff, 32'hffff_ffff, 1'b1));
    pending_reqs.push_back(mk_req(cbfm_pkg::FN_FLUSH, 8'h00, 32'h0, 1'b0));
    pending_reqs.push_back(mk_req(3'd5, 8'hff, 32'hffff_ffff, 1'b1));
    pending_reqs.push_back(mk_req(3'd7, 8'h00, 32'h0, 1'b0));
    pending_reqs.push_back(mk_req(cbfm_pkg::FN_READ, 8'hff, 32'hffff_ffff, 1'b0));
    pending_reqs.push_back(mk_req(cbfm_pkg::FN_READ, 8'hff, 32'hffff_ffff, 1'b0)); // hit
    pending_reqs.push_back(mk_req(cbfm_pkg::FN_ALLOC, 8'hff, 32'hffff_ffff, 1'b0)); // resident
    pending_reqs.push_back(mk_req(cbfm_pkg::FN_UNPIN, 8'hff, 32'hffff_ffff, 1'b1));
    pending_reqs.push_back(mk_req(cbfm_pkg::FN_UNPIN, 8'hff, 32'hffff_ffff, 1'b0));
    pending_reqs.push_back(mk_req(cbfm_pkg::FN_UNPIN, 8'hff, 32'hffff_ffff, 1'b0));
    pending_reqs.push_back(mk_req(cbfm_pkg::FN_UNPIN, 8'hff, 32'hffff_ffff, 1'b0)); // not pinned
    pending_reqs.push_back(mk_req(cbfm_pkg::FN_ALLOC, 8'h00, 32'h0, 1'b0));
    pending_reqs.push_back(mk_req(cbfm_pkg::FN_FLUSH, 8'h00, 32'h0, 1'b0)); // pinned stop
    pending_reqs.push_back(mk_req(cbfm_pkg::FN_DISPOSE, 8'h00, 32'h0, 1'b0)); // dispose pinned
    pending_reqs.push_back(mk_req(cbfm_pkg::FN_FLUSH, 8'hff, 32'h0, 1'b0)); // dirty writeback
    // fill the table with pinned pages, then one more to exhaust the sweep
    for (int i = 0; i <= NF; i++)
      pending_reqs.push_back(mk_req(cbfm_pkg::FN_READ, 8'h5a, 32'(i), 1'b0));
    drain_phase();

    // random: release the pinned pages, then phases with various idling
    for (int i = 0; i < NF; i++)
      pending_reqs.push_back(mk_req(cbfm_pkg::FN_UNPIN, 8'h5a, 32'(i), 1'(i)));
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 33 : 61) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 33 : 61) : 0;
      nrand = 70;
      for (int i = 0; i < nrand; i++) pending_reqs.push_back(rand_req());
      drain_phase();
    end
    repeat (4 * NF + 20) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0)
      $display("tb_clock_buffer_frame_manager: clean");
    else
      $display("tb_clock_buffer_frame_manager: errors");
    $finish;
  end
endmodule
